>>> rtl/shmt_pkg.sv
package shmt_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	localparam int XY_W = 36;
	localparam int Z_W = 28;

	// atan(2^-i) in Q.24 radians
	localparam logic signed [Z_W-1:0] ATAN_Q24 [ATAN_LEN] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
		28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
		28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32,
		28'sd16, 28'sd8, 28'sd4, 28'sd2
	};

	localparam logic signed [29:0] PI_Q24 = 30'sd52707179;
	localparam logic signed [29:0] TWO_PI_Q24 = 30'sd105414358;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [63:0] NEAR_LIM64 = ((64'd6554 << 30) - 64'd1) / 64'd652032874;
	localparam logic [63:0] RECIP_Q40_64 = ((64'd1 << 40) + 64'd1228) / 64'd1229;
	localparam logic [15:0] BOUND_Q13 = 16'd1229;
	localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
	localparam logic [12:0] ONE_Q12 = 13'd4096;
	localparam logic [16:0] TINY_Q12 = 17'd41;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic [1:0] REG_MAX_LIN = 2'd0;
	localparam logic [1:0] REG_MAX_TURN = 2'd1;
	localparam logic [1:0] REG_MIN_TURN = 2'd2;

	typedef struct packed {
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [15:0] cur_heading;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
	} in_word_t;

	typedef struct packed {
		logic [14:0]        linear_cmd;
		logic signed [15:0] angular_cmd;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] head;
		logic               near;
		logic signed [16:0] w;
		logic               cos_en;
	} side_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		side_t                  side;
	} cordic_t;

endpackage

>>> rtl/shmt_cell.sv
module shmt_cell import shmt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rotate,
	input  logic [4:0]            shamt,
	input  logic signed [Z_W-1:0] angle,
	input  logic                  vld_in,
	input  cordic_t               d_in,
	output logic                  vld_out,
	output cordic_t               d_out
);

	logic signed [XY_W-1:0] xs, ys;
	logic neg;
	cordic_t nxt;

	always_comb begin
		xs = d_in.x >>> shamt;
		ys = d_in.y >>> shamt;
		// vectoring drives y to zero, rotation drives z to zero
		neg = rotate ? (d_in.z >= 0) : (d_in.y < 0);
		nxt = d_in;
		if (neg) begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.z = d_in.z - angle;
		end else begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.z = d_in.z + angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out <= nxt;
	end

endmodule

>>> rtl/sliding_mode_heading_tracker.sv
// sliding-mode heading tracker
// input channel: a pose word (robot x, y, heading and look-ahead target)
//   is taken at every rising edge where start is high and busy is low;
//   busy stays low, so a new word may enter every cycle
// output channel: result_valid is high for one cycle with the command word
//   (linear_cmd, angular_cmd) on result; the receiver cannot stall it and
//   must take it in that cycle
// latency: 2*CORDIC_N + 6 cycles from accept to strobe (38 at 16 stages),
//   set by two chains of CORDIC cells (bearing/distance, then cos of error)
//   plus six single-cycle stages for setup, error wrap, divide by the
//   boundary width, turn term, speed multiply and output limits
// throughput: one word per cycle, fully pipelined
// config: cfg_we writes cfg_data into register cfg_idx at once (0 max linear
//   speed, 1 max turn rate, 2 min turn rate); write only while the pipe is empty
// reset: pipeline valid bits clear, registers return to 2048 / 4096 / 410
module sliding_mode_heading_tracker import shmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    pose,
	output logic        result_valid,
	output out_word_t   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [14:0] cfg_data
);

	// config registers
	logic [14:0] max_lin_q, max_turn_q, min_turn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q  <= 15'd2048;
			max_turn_q <= 15'd4096;
			min_turn_q <= 15'd410;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_LIN:  max_lin_q  <= cfg_data;
				REG_MAX_TURN: max_turn_q <= cfg_data;
				REG_MIN_TURN: min_turn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe never stalls
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// setup stage: delta vector, folded into the right half plane
	logic signed [32:0] dx, dy;
	cordic_t vec_init;

	always_comb begin
		dx = 33'(pose.target_x) - 33'(pose.cur_x);
		dy = 33'(pose.target_y) - 33'(pose.cur_y);
		vec_init = '0;
		vec_init.side.head = pose.cur_heading;
		if (dx < 0) begin
			vec_init.x = -XY_W'(dx);
			vec_init.y = -XY_W'(dy);
			vec_init.z = (dy >= 0) ? Z_W'(PI_Q24) : -Z_W'(PI_Q24);
		end else begin
			vec_init.x = XY_W'(dx);
			vec_init.y = XY_W'(dy);
			vec_init.z = '0;
		end
	end

	logic    vec_vld [CORDIC_N+1];
	cordic_t vec_d   [CORDIC_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_vld[0] <= 1'b0;
		end else begin
			vec_vld[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		vec_d[0] <= vec_init;
	end

	// bearing and distance chain
	for (genvar g = 0; g < CORDIC_N; g++) begin : g_vec
		shmt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rotate  (1'b0),
			.shamt   (5'(g)),
			.angle   (ATAN_Q24[g]),
			.vld_in  (vec_vld[g]),
			.d_in    (vec_d[g]),
			.vld_out (vec_vld[g+1]),
			.d_out   (vec_d[g+1])
		);
	end

	// stage 1: near test, heading error wrapped and rounded to Q3.13
	cordic_t vec_o;
	logic signed [29:0] err, err_w;
	logic signed [29:0] e_rnd;
	logic near;
	assign vec_o = vec_d[CORDIC_N];

	always_comb begin
		near = vec_o.x <= $signed({1'b0, NEAR_LIM64[XY_W-2:0]});
		err = 30'(vec_o.z) - (30'(vec_o.side.head) <<< 11);
		if (err > PI_Q24) begin
			err_w = err - TWO_PI_Q24;
		end else if (err < -PI_Q24) begin
			err_w = err + TWO_PI_Q24;
		end else begin
			err_w = err;
		end
		e_rnd = (err_w + 30'sd1024) >>> 11;
	end

	logic               vld_s1;
	logic signed [16:0] e13_s1;
	logic               near_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vec_vld[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		e13_s1  <= 17'(e_rnd);
		near_s1 <= near;
	end

	// stage 2: boundary-layer quotient by reciprocal multiply
	logic [15:0] abs_e;
	logic [22:0] numer;

	always_comb begin
		abs_e = (e13_s1 < 0) ? 16'(-e13_s1) : 16'(e13_s1);
		numer = {abs_e[10:0], 12'd0} + 23'd614;
	end

	logic               vld_s2;
	logic signed [16:0] e13_s2;
	logic [15:0]        abs_s2;
	logic               near_s2;
	logic [52:0]        quot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		e13_s2  <= e13_s1;
		abs_s2  <= abs_e;
		near_s2 <= near_s1;
		quot_s2 <= 53'(numer) * 53'(RECIP_Q40_64[29:0]);
	end

	// stage 3: turn term, start of cos rotation
	logic [12:0] sat_mag;
	cordic_t rot_init;

	always_comb begin
		sat_mag = (abs_s2 > BOUND_Q13) ? ONE_Q12 : quot_s2[52:40];
		rot_init = '0;
		rot_init.x = XY_W'(INV_GAIN_Q30);
		rot_init.y = '0;
		rot_init.z = Z_W'(e13_s2) <<< 11;
		rot_init.side.near = near_s2;
		rot_init.side.cos_en = abs_s2 <= HALF_PI_Q13;
		rot_init.side.w = (e13_s2 < 0) ? (e13_s2 - 17'(sat_mag))
			: (e13_s2 + 17'(sat_mag));
	end

	logic    rot_vld [CORDIC_N+1];
	cordic_t rot_d   [CORDIC_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_vld[0] <= 1'b0;
		end else begin
			rot_vld[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rot_d[0] <= rot_init;
	end

	// cos chain
	for (genvar g = 0; g < CORDIC_N; g++) begin : g_rot
		shmt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rotate  (1'b1),
			.shamt   (5'(g)),
			.angle   (ATAN_Q24[g]),
			.vld_in  (rot_vld[g]),
			.d_in    (rot_d[g]),
			.vld_out (rot_vld[g+1]),
			.d_out   (rot_d[g+1])
		);
	end

	// stage 4: clamp cos, scale by max linear speed
	cordic_t rot_o;
	logic [30:0] cos_c;
	assign rot_o = rot_d[CORDIC_N];

	always_comb begin
		if (rot_o.x < 0) begin
			cos_c = '0;
		end else if (rot_o.x > $signed(XY_W'(ONE_Q30))) begin
			cos_c = ONE_Q30;
		end else begin
			cos_c = rot_o.x[30:0];
		end
	end

	logic        vld_s4;
	side_t       side_s4;
	logic [45:0] vprod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= rot_vld[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		side_s4  <= rot_o.side;
		vprod_s4 <= 46'(max_lin_q) * 46'(cos_c);
	end

	// stage 5: near override, zero speed outside the cos window, turn limits
	logic [14:0]        v_fin;
	logic signed [16:0] w_pre, w_fin;
	logic [16:0]        w_abs;

	always_comb begin
		v_fin = (side_s4.near || !side_s4.cos_en) ? 15'd0 : vprod_s4[44:30];
		w_pre = side_s4.near ? 17'sd0 : side_s4.w;
		w_abs = (w_pre < 0) ? 17'(-w_pre) : 17'(w_pre);
		w_fin = w_pre;
		if (w_abs > 17'(max_turn_q)) begin
			w_fin = (w_pre < 0) ? -$signed(17'(max_turn_q)) : $signed(17'(max_turn_q));
		end else if (w_abs < 17'(min_turn_q) && w_abs >= TINY_Q12) begin
			w_fin = (w_pre < 0) ? -$signed(17'(min_turn_q)) : $signed(17'(min_turn_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		result.linear_cmd  <= v_fin;
		result.angular_cmd <= w_fin[15:0];
	end

endmodule

>>> tb/sv/tb_sliding_mode_heading_tracker.sv
module tb_sliding_mode_heading_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import shmt_pkg::*;

	// wait longer than the pipe depth before config writes
	localparam int PIPE_WAIT = 2 * CORDIC_N + 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    pose;
	logic        result_valid;
	out_word_t   result;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [14:0] cfg_data;

	sliding_mode_heading_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pose(pose),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// shadow of the speed limits, matching the block's registers
	longint lin_lim, turn_max, turn_min;

	in_word_t  pose_q[$];
	out_word_t cmd_q[$];
	int        mismatches;
	bit        driver_idle_off;   // no gaps near the end of the run
	bit        hold_off;          // sender pauses while set
	int        gap_left;

	// atan(2^-i), Q.24
	localparam longint ATAN_TBL [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};
	localparam longint PI24 = 52707179;
	localparam longint INV_K30 = 652032874;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// steering law: bearing and distance by vectoring, cos by rotation
	function automatic out_word_t steer_cmd(in_word_t p);
		longint dx, dy, x, y, z, e, e13, a, w, v, q, cx, cy, cz, xs, ys;
		bit near;
		out_word_t r;
		dx = longint'(p.target_x) - longint'(p.cur_x);
		dy = longint'(p.target_y) - longint'(p.cur_y);
		x = dx; y = dy; z = 0; v = 0;
		if (x < 0) begin
			z = (y >= 0) ? PI24 : -PI24;
			x = -x; y = -y;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_TBL[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TBL[i];
			end
		end
		near = (x < (64'sd1 <<< 33)) && (((x * INV_K30) >>> 30) < 6554);
		e = z - longint'(p.cur_heading) * 2048;
		while (e > PI24) e -= 2 * PI24;
		while (e < -PI24) e += 2 * PI24;
		e13 = (e + 1024) >>> 11;
		a = (e13 < 0) ? -e13 : e13;
		// boundary layer: saturated sign term
		if (a > 1229)
			w = e13 + ((e13 < 0) ? -4096 : 4096);
		else begin
			q = (a * 4096 + 614) / 1229;
			w = e13 + ((e13 < 0) ? -q : q);
		end
		if (a <= 12868) begin
			cx = INV_K30; cy = 0; cz = e13 * 2048;
			for (int i = 0; i < CORDIC_N; i++) begin
				xs = cx >>> i; ys = cy >>> i;
				if (cz >= 0) begin
					cx -= ys; cy += xs; cz -= ATAN_TBL[i];
				end else begin
					cx += ys; cy -= xs; cz += ATAN_TBL[i];
				end
			end
			if (cx < 0) cx = 0;
			if (cx > (64'sd1 <<< 30)) cx = 64'sd1 <<< 30;
			v = (lin_lim * cx) >>> 30;
		end
		if (near) begin
			v = 0; w = 0;
		end
		if (v > lin_lim) v = lin_lim;
		a = (w < 0) ? -w : w;
		if (a > turn_max)
			w = (w < 0) ? -turn_max : turn_max;
		else if (a < turn_min && a >= 41)
			w = (w < 0) ? -turn_min : turn_min;
		r.linear_cmd = v[14:0];
		r.angular_cmd = w[15:0];
		return r;
	endfunction

	// driver: pops pose words, random gap bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			pose <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				cmd_q.push_back(steer_cmd(pose));
			end
			if (start && busy) begin
				// word still pending, hold it
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (!driver_idle_off && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 12);
				start <= 1'b0;
			end else if (pose_q.size() > 0 && !hold_off) begin
				pose <= pose_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobe checks the oldest expected command word
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (cmd_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected command word lin=%0d ang=%0d",
						result.linear_cmd, result.angular_cmd);
			end else begin
				out_word_t want;
				want = cmd_q.pop_front();
				if (want.linear_cmd !== result.linear_cmd ||
				    want.angular_cmd !== result.angular_cmd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: lin exp %0d got %0d, ang exp %0d got %0d",
							want.linear_cmd, result.linear_cmd,
							want.angular_cmd, result.angular_cmd);
				end
			end
		end
	end

	function automatic in_word_t rand_pose(bit tight);
		in_word_t p;
		p.cur_x = $urandom;
		p.cur_y = $urandom;
		p.cur_heading = (tight || $urandom_range(0, 3) != 0) ?
			16'($signed($urandom_range(0, 51472)) - 25736) : 16'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				// target close by, often inside the near radius
				p.target_x = p.cur_x + $signed($urandom_range(0, 16000)) - 8000;
				p.target_y = p.cur_y + $signed($urandom_range(0, 16000)) - 8000;
			end
			1, 2: begin
				// look-ahead a few meters away
				p.target_x = p.cur_x + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
				p.target_y = p.cur_y + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			end
			3: begin
				// heading nearly on the bearing, small turn terms
				p.target_x = p.cur_x + $urandom_range(65536, 1 << 20);
				p.target_y = p.cur_y + $signed($urandom_range(0, 4000)) - 2000;
				p.cur_heading = 16'($signed($urandom_range(0, 1600)) - 800);
			end
			default: begin
				p.target_x = $urandom;
				p.target_y = $urandom;
			end
		endcase
		return p;
	endfunction

	function automatic in_word_t mk_pose(int cx, int cy, int hd, int tx, int ty);
		in_word_t p;
		p.cur_x = cx; p.cur_y = cy; p.cur_heading = 16'(hd);
		p.target_x = tx; p.target_y = ty;
		return p;
	endfunction

	task automatic wait_drain();
		while (pose_q.size() > 0 || start || cmd_q.size() > 0)
			@(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		cfg_idx <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_LIN: lin_lim = val;
			REG_MAX_TURN: turn_max = val;
			REG_MIN_TURN: turn_min = val;
			default: ;
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_LIN;
		cfg_data = '0;
		mismatches = 0;
		driver_idle_off = 1'b0;
		hold_off = 1'b0;
		lin_lim = 2048; turn_max = 4096; turn_min = 410;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: target at robot, field extremes, headings out of range
		pose_q.push_back(mk_pose(0, 0, 0, 0, 0));
		pose_q.push_back(mk_pose(-32'sh8000_0000, -32'sh8000_0000, 25736,
			32'sh7fff_ffff, 32'sh7fff_ffff));
		pose_q.push_back(mk_pose(32'sh7fff_ffff, 32'sh7fff_ffff, -25736,
			-32'sh8000_0000, -32'sh8000_0000));
		pose_q.push_back(mk_pose(0, 0, 32767, 65536, 0));
		pose_q.push_back(mk_pose(0, 0, -32768, 65536, 0));
		pose_q.push_back(mk_pose(0, 0, 0, -65536, 0));
		pose_q.push_back(mk_pose(0, 0, 0, -65536, -1));
		pose_q.push_back(mk_pose(0, 0, 0, 0, 65536));
		pose_q.push_back(mk_pose(0, 0, 0, 6553, 0));
		pose_q.push_back(mk_pose(0, 0, 0, 6560, 0));
		pose_q.push_back(mk_pose(0, 0, 100, 65536, 0));
		pose_q.push_back(mk_pose(0, 0, 1229, 65536, 0));
		pose_q.push_back(mk_pose(0, 0, 12868, 65536, 0));
		pose_q.push_back(mk_pose(100, -100, -12000, 65536, 32768));
		pose_q.push_back(mk_pose(-1, -1, 0, 0, 0));
		wait_drain();

		// several register settings, extremes included, min above max in phases 1 and 2
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MAX_LIN, 15'h7fff); write_reg(REG_MAX_TURN, 15'h7fff);
					write_reg(REG_MIN_TURN, 0);
				end
				1: begin
					write_reg(REG_MAX_LIN, 0); write_reg(REG_MAX_TURN, 0);
					write_reg(REG_MIN_TURN, 15'h7fff);
				end
				2: begin
					write_reg(REG_MAX_LIN, 1000); write_reg(REG_MAX_TURN, 300);
					write_reg(REG_MIN_TURN, 2000);
				end
				3: begin
					write_reg(2'd3, 15'h1234); // unmapped index, ignored
					write_reg(REG_MAX_LIN, 15'($urandom)); write_reg(REG_MAX_TURN,
						15'($urandom_range(0, 8000)));
					write_reg(REG_MIN_TURN, 15'($urandom_range(0, 3000)));
				end
				default: begin
					write_reg(REG_MAX_LIN, 2048); write_reg(REG_MAX_TURN, 4096);
					write_reg(REG_MIN_TURN, 410);
				end
			endcase
			if (ph == 5) driver_idle_off = 1'b1;
			for (int k = 0; k < 165; k++)
				pose_q.push_back(rand_pose(ph == 4));
			if (ph == 2) begin
				// sender holds until every pending command word is back
				while (pose_q.size() > 80) @(posedge clk);
				hold_off = 1'b1;
				while (start || cmd_q.size() > 0) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_drain();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
